FILE: rtl/gbn_pkg.sv
// Shared types, constants and helpers for the go-back-N sender window.
// No dependencies; every other file in rtl/ imports this package.
package gbn_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int SEQ_W      = 4;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_LVL_W    = $clog2(Q_DEPTH + 1);

  localparam logic [3:0] WINDOW_SIZE_RESET = 4'd4;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_SEND    = 3'd1,
    OP_ACK     = 3'd2,
    OP_NAK     = 3'd3,
    OP_TIMEOUT = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_STARTED = 3'd0,
    ST_SENT    = 3'd1,
    ST_FULL    = 3'd2,
    ST_SLID    = 3'd3,
    ST_IGNORED = 3'd4,
    ST_RETX    = 3'd5,
    ST_NONE    = 3'd6
  } status_e;

  // One queued command: a single result, or a retransmit burst of count numbers
  // starting at seq.
  typedef struct packed {
    logic    burst;
    status_e status;
    seq_t    seq;
    cnt_t    count;
    seq_t    mask;
  } cmd_t;

  // Window size clamped to 1..MAX_WINDOW.
  function automatic cnt_t eff_window(input logic [3:0] ws);
    cnt_t w;
    w = ws;
    if (w < cnt_t'(1)) w = cnt_t'(1);
    if (w > cnt_t'(MAX_WINDOW)) w = cnt_t'(MAX_WINDOW);
    return w;
  endfunction

  // Largest sequence number: 2^b - 1 with 2^b >= window + 1.
  function automatic seq_t seq_mask(input logic [3:0] ws);
    cnt_t w;
    seq_t m;
    w = eff_window(ws);
    if (w >= cnt_t'(8))      m = seq_t'(15);
    else if (w >= cnt_t'(4)) m = seq_t'(7);
    else if (w >= cnt_t'(2)) m = seq_t'(3);
    else                     m = seq_t'(1);
    return m;
  endfunction

endpackage

FILE: rtl/gbn_front.sv
// Front end: accepts items, keeps the window state and classifies each item
// into one queued command. Depends on gbn_pkg.
module gbn_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [3:0]    cfg_wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    opcode,
  input  logic [3:0]    seq_number,
  input  logic          q_full,
  output logic          q_push,
  output gbn_pkg::cmd_t q_cmd
);
  import gbn_pkg::*;

  logic [3:0] window_size;
  seq_t       window_base, window_base_next;
  cnt_t       window_count, window_count_next;
  seq_t       next_seq, next_seq_next;

  seq_t m, base_m, off, prev, poff, sq;
  cnt_t w;
  logic s_in, p_in;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    m      = seq_mask(window_size);
    w      = eff_window(window_size);
    base_m = window_base & m;
    off    = (seq_number - base_m) & m;
    s_in   = (seq_number <= m) && (cnt_t'(off) < window_count);
    prev   = (seq_number == seq_t'(0)) ? m : seq_number - seq_t'(1);
    poff   = (prev - base_m) & m;
    p_in   = (seq_number <= m) && (cnt_t'(poff) < window_count);
    sq     = next_seq & m;

    window_base_next  = window_base;
    window_count_next = window_count;
    next_seq_next     = next_seq;

    q_cmd.burst  = 1'b0;
    q_cmd.status = ST_IGNORED;
    q_cmd.seq    = seq_t'(0);
    q_cmd.mask   = m;

    unique case (opcode_e'(opcode))
      OP_START: begin
        window_count_next = cnt_t'(0);
        next_seq_next     = seq_number & m;
        window_base_next  = seq_number & m;
        q_cmd.status      = ST_STARTED;
      end
      OP_SEND: begin
        if (window_count >= w) begin
          q_cmd.status = ST_FULL;
        end else begin
          if (window_count == cnt_t'(0)) window_base_next = sq;
          window_count_next = window_count + cnt_t'(1);
          next_seq_next     = (sq + seq_t'(1)) & m;
          q_cmd.status      = ST_SENT;
          q_cmd.seq         = sq;
        end
      end
      OP_ACK: begin
        if (s_in) begin
          window_count_next = window_count - cnt_t'(off) - cnt_t'(1);
          window_base_next  = (seq_number + seq_t'(1)) & m;
          q_cmd.status      = ST_SLID;
        end
      end
      OP_NAK: begin
        if (s_in) begin
          // drop everything before the naked number, resend the rest
          window_count_next = window_count - cnt_t'(off);
          window_base_next  = seq_number;
          q_cmd.burst       = 1'b1;
          q_cmd.status      = ST_RETX;
          q_cmd.seq         = seq_number;
        end else if (p_in) begin
          window_count_next = cnt_t'(0);
          window_base_next  = seq_number;
          q_cmd.status      = ST_SLID;
        end
      end
      OP_TIMEOUT: begin
        if (window_count == cnt_t'(0)) begin
          q_cmd.status = ST_NONE;
        end else begin
          q_cmd.burst  = 1'b1;
          q_cmd.status = ST_RETX;
          q_cmd.seq    = base_m;
        end
      end
      default: begin
        q_cmd.status = ST_IGNORED;
      end
    endcase

    q_cmd.count = window_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WINDOW_SIZE_RESET;
      window_base  <= seq_t'(0);
      window_count <= cnt_t'(0);
      next_seq     <= seq_t'(0);
    end else if (cfg_wr_en) begin
      // empty the window and fold state into the new sequence space
      window_size  <= cfg_wr_data;
      window_count <= cnt_t'(0);
      window_base  <= window_base & seq_mask(cfg_wr_data);
      next_seq     <= next_seq & seq_mask(cfg_wr_data);
    end else if (q_push) begin
      window_base  <= window_base_next;
      window_count <= window_count_next;
      next_seq     <= next_seq_next;
    end
  end

endmodule

FILE: rtl/gbn_queue.sv
// Short command queue between front and back end.
// Depends on gbn_pkg for the command type and depth.
module gbn_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  gbn_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output gbn_pkg::cmd_t          head,
  output logic                   empty,
  output logic                   full,
  output logic [gbn_pkg::Q_LVL_W-1:0] level
);
  import gbn_pkg::*;

  cmd_t                mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [Q_LVL_W-1:0]  cnt;

  assign empty = (cnt == Q_LVL_W'(0));
  assign full  = (cnt == Q_LVL_W'(Q_DEPTH));
  assign level = cnt;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      if (push && !pop)      cnt <= cnt + Q_LVL_W'(1);
      else if (pop && !push) cnt <= cnt - Q_LVL_W'(1);
    end
  end

endmodule

FILE: rtl/gbn_back.sv
// Back end: turns queued commands into result items, one per cycle unless
// stalled, walking retransmit bursts number by number. Depends on gbn_pkg.
module gbn_back (
  input  logic          clk,
  input  logic          rst,
  input  gbn_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    status,
  output logic [3:0]    out_seq,
  output logic [3:0]    in_flight,
  output logic          last
);
  import gbn_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             load;
  logic             burst_last;
  seq_t             burst_seq;

  assign load       = !q_empty && (!out_valid || !out_stall);
  assign burst_seq  = (head.seq + seq_t'(idx)) & head.mask;
  assign burst_last = (cnt_t'(idx) + cnt_t'(1) == head.count);
  assign q_pop      = load && (!head.burst || burst_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        // advance through the burst, rewind on its final number
        if (head.burst) idx <= burst_last ? '0 : idx + IDX_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status    <= head.status;
      in_flight <= head.count;
      out_seq   <= head.burst ? burst_seq : head.seq;
      last      <= head.burst ? burst_last : 1'b1;
    end
  end

endmodule

FILE: rtl/go_back_n_sender_window_core.sv
// Go-back-N sender window. Each accepted item (start, send, ack, nak,
// timeout) is classified in the same cycle by the front end and queued as one
// command; the back end then emits one result item per cycle, while out_stall
// is low, from a registered output. A single-result item takes one output
// slot; a nak or timeout that retransmits emits one result per outstanding
// number (up to the window size), and input is stalled only once the two-entry
// command queue is full. Throughput is therefore set by the back end's single
// output register. Write window_size only while no results are pending.
// Depends on gbn_pkg, gbn_front, gbn_queue, gbn_back.
module go_back_n_sender_window_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [3:0] seq_number,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [3:0] out_seq,
  output logic [3:0] in_flight,
  output logic       last
);
  import gbn_pkg::*;

  cmd_t               push_cmd, head;
  logic               push, pop, q_empty, q_full;
  logic [Q_LVL_W-1:0] q_level;

  gbn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .seq_number  (seq_number),
    .q_full      (q_full),
    .q_push      (push),
    .q_cmd       (push_cmd)
  );

  gbn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full),
    .level    (q_level)
  );

  gbn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_seq   (out_seq),
    .in_flight (in_flight),
    .last      (last)
  );

  a_retx_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_RETX) |-> (in_flight != 4'd0))
    else $error("retransmit with empty window");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_RETX) |-> last)
    else $error("single result without last marker");

  a_seq_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_RETX && status != ST_SENT) |-> (out_seq == 4'd0))
    else $error("nonzero sequence on status result");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (q_level == Q_LVL_W'(Q_DEPTH)) |=> (q_level <= Q_LVL_W'(Q_DEPTH)))
    else $error("command queue overflow");

endmodule
